FILE: hw/rtl/qse_pkg.sv
// qse_pkg: shared types and default constants of the quicksort engine
// used by qse_cmp, quicksort_engine_unit and the testbench; no dependencies
package qse_pkg;

    // fixed widths of the request and result fields
    localparam int ITEM_W          = 32;

    // defaults for the top level parameters
    localparam int MAX_ELEMS_DEF   = 64;
    localparam int DATA_WIDTH_DEF  = 32;

    // result of one pass through the shared compare unit
    typedef struct packed {
        logic lt;
        logic gt;
    } cmp_res_t;

endpackage

FILE: hw/rtl/qse_ram.sv
// qse_ram: generic single write port, single read port memory with registered read
// no package dependencies
module qse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/qse_cmp.sv
// qse_cmp: shared signed two's complement compare used by both partition scans
// depends on qse_pkg for the result struct
module qse_cmp #(
    parameter int DATA_WIDTH = 32
) (
    input  logic signed [DATA_WIDTH-1:0] a,
    input  logic signed [DATA_WIDTH-1:0] b,
    output qse_pkg::cmp_res_t            res
);
    import qse_pkg::*;

    always_comb begin
        res.lt = (a < b);
        res.gt = (a > b);
    end

endmodule

FILE: hw/rtl/quicksort_engine_unit.sv
// quicksort_engine_unit: loads one value per request until end of set, sorts the set
// in place by quicksort (middle pivot, two converging scans, explicit range stack)
// load: s_ready stays high, so requests are taken back to back; sort: scan steps go one at a
// time through the single store read port; emit: 1 per cycle unless stalled by m_ready;
// s_ready is low from the end of set request until the last result is loaded
// reset is synchronous active low and clears control state only; no clearing pass
module quicksort_engine_unit #(
    parameter int MAX_ELEMS  = qse_pkg::MAX_ELEMS_DEF,
    parameter int DATA_WIDTH = qse_pkg::DATA_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [qse_pkg::ITEM_W-1:0] s_item_value,
    input  logic                              s_end_of_set,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [qse_pkg::ITEM_W-1:0] m_sorted_value,
    output logic                              m_last_out,
    output logic                              m_overflowed
);
    import qse_pkg::*;

    localparam int IDX_W = $clog2(MAX_ELEMS);
    localparam int CNT_W = $clog2(MAX_ELEMS + 1);
    localparam int PW    = IDX_W + 2;
    localparam int SK_W  = 2 * IDX_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMS);

    localparam logic [3:0] S_LOAD    = 4'd0;
    localparam logic [3:0] S_POP     = 4'd1;
    localparam logic [3:0] S_POPW    = 4'd2;
    localparam logic [3:0] S_PIV     = 4'd3;
    localparam logic [3:0] S_LCMP    = 4'd4;
    localparam logic [3:0] S_RCMP    = 4'd5;
    localparam logic [3:0] S_SW1     = 4'd6;
    localparam logic [3:0] S_SW2     = 4'd7;
    localparam logic [3:0] S_PUSH1   = 4'd8;
    localparam logic [3:0] S_PUSH2   = 4'd9;
    localparam logic [3:0] S_EMIT_RD = 4'd10;
    localparam logic [3:0] S_EMIT    = 4'd11;

    logic [3:0]                   state_reg, state_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic                         ovf_reg, ovf_next;
    logic [CNT_W-1:0]             sp_reg, sp_next;
    logic [IDX_W-1:0]             lo_reg, lo_next;
    logic [IDX_W-1:0]             hi_reg, hi_next;
    logic signed [PW-1:0]         left_reg, left_next;
    logic signed [PW-1:0]         right_reg, right_next;
    logic signed [DATA_WIDTH-1:0] pk_reg, pk_next;
    logic signed [DATA_WIDTH-1:0] lval_reg, lval_next;
    logic signed [DATA_WIDTH-1:0] rval_reg, rval_next;
    logic [CNT_W-1:0]             emit_idx_reg, emit_idx_next;
    logic                         m_valid_reg, m_valid_next;
    logic signed [ITEM_W-1:0]     out_val_reg, out_val_next;
    logic                         out_last_reg, out_last_next;
    logic                         out_ovf_reg, out_ovf_next;

    logic                         st_we;
    logic [IDX_W-1:0]             st_waddr, st_raddr;
    logic [DATA_WIDTH-1:0]        st_wdata, st_rdata;
    logic                         sk_we;
    logic [IDX_W-1:0]             sk_waddr, sk_raddr;
    logic [SK_W-1:0]              sk_wdata, sk_rdata;

    logic signed [DATA_WIDTH-1:0] in_val;
    logic signed [DATA_WIDTH-1:0] rd_val;
    cmp_res_t                     cmp;
    logic signed [PW-1:0]         lo_s, hi_s, left_p1, left_m1, right_m1;
    logic [CNT_W-1:0]             count_after;
    logic                         accept, load_out, emit_last;

    qse_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_ELEMS)) u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    qse_ram #(.WIDTH(SK_W), .DEPTH(MAX_ELEMS)) u_stack (
        .aclk  (aclk),
        .we    (sk_we),
        .waddr (sk_waddr),
        .wdata (sk_wdata),
        .raddr (sk_raddr),
        .rdata (sk_rdata)
    );

    assign rd_val = $signed(st_rdata);

    qse_cmp #(.DATA_WIDTH(DATA_WIDTH)) u_cmp (
        .a   (rd_val),
        .b   (pk_reg),
        .res (cmp)
    );

    // narrower widths truncate, wider ones sign extend
    assign in_val   = DATA_WIDTH'(s_item_value);
    assign lo_s     = $signed(PW'(lo_reg));
    assign hi_s     = $signed(PW'(hi_reg));
    assign left_p1  = left_reg + PW'(1);
    assign left_m1  = left_reg - PW'(1);
    assign right_m1 = right_reg - PW'(1);

    assign s_ready   = (state_reg == S_LOAD);
    assign accept    = s_valid && s_ready;
    assign load_out  = !m_valid_reg || m_ready;
    assign emit_last = (emit_idx_reg == count_reg - CNT_W'(1));
    assign count_after = (count_reg < MAX_CNT) ? count_reg + CNT_W'(1) : count_reg;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        sp_next       = sp_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        pk_next       = pk_reg;
        lval_next     = lval_reg;
        rval_next     = rval_reg;
        emit_idx_next = emit_idx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        out_val_next  = out_val_reg;
        out_last_next = out_last_reg;
        out_ovf_next  = out_ovf_reg;
        st_we         = 1'b0;
        st_waddr      = count_reg[IDX_W-1:0];
        st_wdata      = in_val;
        st_raddr      = '0;
        sk_we         = 1'b0;
        sk_waddr      = sp_reg[IDX_W-1:0];
        sk_wdata      = '0;
        sk_raddr      = '0;

        case (state_reg)
            S_LOAD: begin
                if (accept) begin
                    if (count_reg < MAX_CNT) begin
                        st_we = 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    count_next = count_after;
                    if (s_end_of_set) begin
                        if (count_after < CNT_W'(2)) begin
                            state_next = S_EMIT_RD;
                        end else begin
                            sk_we      = 1'b1;
                            sk_waddr   = '0;
                            sk_wdata   = {IDX_W'(0), IDX_W'(count_after - CNT_W'(1))};
                            sp_next    = CNT_W'(1);
                            state_next = S_POP;
                        end
                    end
                end
            end
            S_POP: begin
                if (sp_reg == '0) begin
                    state_next = S_EMIT_RD;
                end else begin
                    sk_raddr   = IDX_W'(sp_reg - CNT_W'(1));
                    sp_next    = sp_reg - CNT_W'(1);
                    state_next = S_POPW;
                end
            end
            S_POPW: begin
                lo_next    = sk_rdata[SK_W-1:IDX_W];
                hi_next    = sk_rdata[IDX_W-1:0];
                left_next  = $signed(PW'(sk_rdata[SK_W-1:IDX_W]));
                right_next = $signed(PW'(sk_rdata[IDX_W-1:0]));
                st_raddr   = IDX_W'((IDX_W + 1)'(sk_rdata[SK_W-1:IDX_W])
                             + (IDX_W + 1)'(sk_rdata[IDX_W-1:0]) >> 1);
                state_next = S_PIV;
            end
            S_PIV: begin
                pk_next    = rd_val;
                st_raddr   = left_reg[IDX_W-1:0];
                state_next = S_LCMP;
            end
            S_LCMP: begin
                // read data belongs to the left index
                if (left_reg < hi_s && cmp.lt) begin
                    left_next = left_p1;
                    st_raddr  = left_p1[IDX_W-1:0];
                end else begin
                    lval_next  = rd_val;
                    st_raddr   = right_reg[IDX_W-1:0];
                    state_next = S_RCMP;
                end
            end
            S_RCMP: begin
                if (right_reg > lo_s && cmp.gt) begin
                    right_next = right_m1;
                    st_raddr   = right_m1[IDX_W-1:0];
                end else begin
                    rval_next = rd_val;
                    if (left_reg <= right_reg) begin
                        state_next = S_SW1;
                    end else begin
                        state_next = S_PUSH1;
                    end
                end
            end
            S_SW1: begin
                st_we      = 1'b1;
                st_waddr   = left_reg[IDX_W-1:0];
                st_wdata   = rval_reg;
                state_next = S_SW2;
            end
            S_SW2: begin
                st_we      = 1'b1;
                st_waddr   = right_reg[IDX_W-1:0];
                st_wdata   = lval_reg;
                st_raddr   = left_p1[IDX_W-1:0];
                left_next  = left_p1;
                right_next = right_m1;
                if (left_p1 <= right_m1) begin
                    state_next = S_LCMP;
                end else begin
                    state_next = S_PUSH1;
                end
            end
            S_PUSH1: begin
                if (lo_s < left_m1 && sp_reg < MAX_CNT) begin
                    sk_we    = 1'b1;
                    sk_wdata = {lo_reg, left_m1[IDX_W-1:0]};
                    sp_next  = sp_reg + CNT_W'(1);
                end
                state_next = S_PUSH2;
            end
            S_PUSH2: begin
                if (left_reg < hi_s && sp_reg < MAX_CNT) begin
                    sk_we    = 1'b1;
                    sk_wdata = {left_reg[IDX_W-1:0], hi_reg};
                    sp_next  = sp_reg + CNT_W'(1);
                end
                state_next = S_POP;
            end
            S_EMIT_RD: begin
                st_raddr      = '0;
                emit_idx_next = '0;
                state_next    = S_EMIT;
            end
            S_EMIT: begin
                // hold the read address while the result register is stalled
                st_raddr = emit_idx_reg[IDX_W-1:0];
                if (load_out) begin
                    st_raddr      = IDX_W'(emit_idx_reg + CNT_W'(1));
                    m_valid_next  = 1'b1;
                    out_val_next  = ITEM_W'(rd_val);
                    out_last_next = emit_last;
                    out_ovf_next  = ovf_reg;
                    emit_idx_next = emit_idx_reg + CNT_W'(1);
                    if (emit_last) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        sp_next    = '0;
                        state_next = S_LOAD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            sp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            sp_reg      <= sp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        pk_reg       <= pk_next;
        lval_reg     <= lval_next;
        rval_reg     <= rval_next;
        emit_idx_reg <= emit_idx_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_sorted_value = out_val_reg;
    assign m_last_out     = out_last_reg;
    assign m_overflowed   = out_ovf_reg;

endmodule

FILE: tb/sv/tb_quicksort_engine_unit.sv
// tb_quicksort_engine_unit: self-checking bench for the quicksort engine, sorts each set in
// its own predictor and compares every result field; needs qse_pkg and quicksort_engine_unit
module tb_quicksort_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import qse_pkg::*;

    localparam int                 CAPACITY       = MAX_ELEMS_DEF;
    localparam int                 IDLE_PCT       = 7;
    localparam int                 RX_HOLD_CYCLES = 500;
    localparam int                 WATCHDOG_LIMIT = 50000;
    localparam int                 ITEMS_TARGET   = 370;
    localparam logic signed [31:0] MOST_NEG       = 32'sh8000_0000;
    localparam logic signed [31:0] MOST_POS       = 32'sh7fff_ffff;

    typedef enum int {
        VALUES_WIDE,
        VALUES_CLUSTERED,
        VALUES_EXTREME
    } value_mix_t;

    typedef struct packed {
        logic signed [ITEM_W-1:0] value;
        logic                     last;
        logic                     ovf;
    } sorted_entry_t;

    logic                     aclk           = 1'b0;
    logic                     aresetn        = 1'b0;
    logic                     s_valid        = 1'b0;
    logic                     s_ready;
    logic signed [ITEM_W-1:0] s_item_value   = '0;
    logic                     s_end_of_set   = 1'b0;
    logic                     m_valid;
    logic                     m_ready        = 1'b0;
    logic signed [ITEM_W-1:0] m_sorted_value;
    logic                     m_last_out;
    logic                     m_overflowed;

    // predictor copy of the block's store
    logic signed [ITEM_W-1:0] set_buf [CAPACITY];
    int                       set_count;
    logic                     set_dropped;
    sorted_entry_t            pending_sorted [$];

    int mismatch_count;
    int requests_sent;
    int sets_closed;
    int overflow_sets;
    int results_checked;
    int quiet_cycles;
    int hold_asked;
    int hold_served;
    int hold_left;
    bit tx_quiet;
    bit rx_quiet;

    quicksort_engine_unit uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_item_value   (s_item_value),
        .s_end_of_set   (s_end_of_set),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sorted_value (m_sorted_value),
        .m_last_out     (m_last_out),
        .m_overflowed   (m_overflowed)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // store the accepted value; on end of set sort in place and queue the expected results
    task automatic predict_sorted_set(input logic signed [ITEM_W-1:0] value, input logic eos);
        int            range_lo [$];
        int            range_hi [$];
        int            lo;
        int            hi;
        int            left;
        int            right;
        int            i;
        logic signed [ITEM_W-1:0] pivot;
        logic signed [ITEM_W-1:0] swap_tmp;
        sorted_entry_t entry;
        if (set_count < CAPACITY) begin
            set_buf[set_count] = value;
            set_count++;
        end else begin
            set_dropped = 1'b1;
        end
        if (!eos) return;
        if (set_count >= 2) begin
            range_lo.push_back(0);
            range_hi.push_back(set_count - 1);
        end
        while (range_lo.size() > 0) begin
            lo    = range_lo.pop_back();
            hi    = range_hi.pop_back();
            left  = lo;
            right = hi;
            pivot = set_buf[(lo + hi) / 2];
            while (left <= right) begin
                while (left < hi && set_buf[left] < pivot) left++;
                while (right > lo && set_buf[right] > pivot) right--;
                if (left <= right) begin
                    swap_tmp       = set_buf[left];
                    set_buf[left]  = set_buf[right];
                    set_buf[right] = swap_tmp;
                    left++;
                    right--;
                end
            end
            if (lo < left - 1) begin
                range_lo.push_back(lo);
                range_hi.push_back(left - 1);
            end
            if (left < hi) begin
                range_lo.push_back(left);
                range_hi.push_back(hi);
            end
        end
        for (i = 0; i < set_count; i++) begin
            entry.value = set_buf[i];
            entry.last  = (i == set_count - 1);
            entry.ovf   = set_dropped;
            pending_sorted.push_back(entry);
        end
        sets_closed++;
        if (set_dropped) overflow_sets++;
        set_count   = 0;
        set_dropped = 1'b0;
    endtask

    task automatic send_request(input logic signed [ITEM_W-1:0] value, input logic eos);
        if (!tx_quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_item_value <= value;
        s_end_of_set <= eos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        requests_sent++;
        predict_sorted_set(value, eos);
    endtask

    task automatic send_random_set(input int size, input value_mix_t mix);
        int                       i;
        logic signed [ITEM_W-1:0] v;
        for (i = 0; i < size; i++) begin
            case (mix)
                VALUES_WIDE: begin
                    v = $urandom;
                end
                VALUES_CLUSTERED: begin
                    v = $urandom_range(0, 8);
                    v = v - 4;
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0:       v = MOST_NEG;
                        1:       v = MOST_POS;
                        2:       v = '0;
                        default: v = -1;
                    endcase
                end
            endcase
            send_request(v, i == size - 1);
        end
    endtask

    // stop offering requests and wait until every expected result has arrived
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_sorted.size() != 0);
    endtask

    task automatic test_single_item_sets();
        send_request(MOST_NEG, 1'b1);
        send_request(MOST_POS, 1'b1);
        send_request('0, 1'b1);
        send_request(-1, 1'b1);
    endtask

    task automatic test_small_sets();
        // extremes in the wrong order
        send_request(MOST_POS, 1'b0);
        send_request(MOST_NEG, 1'b1);
        // all equal
        send_request(5, 1'b0);
        send_request(5, 1'b0);
        send_request(5, 1'b1);
        // already ascending
        send_request(-3, 1'b0);
        send_request(-1, 1'b0);
        send_request(0, 1'b0);
        send_request(7, 1'b1);
        // descending with duplicated extremes
        send_request(MOST_POS, 1'b0);
        send_request(MOST_POS, 1'b0);
        send_request(1, 1'b0);
        send_request(0, 1'b0);
        send_request(MOST_NEG, 1'b0);
        send_request(MOST_NEG, 1'b1);
    endtask

    task automatic test_full_capacity();
        send_random_set(CAPACITY, VALUES_WIDE);
    endtask

    task automatic test_overflow();
        // one request past capacity: the end of set request itself is dropped
        send_random_set(CAPACITY + 1, VALUES_CLUSTERED);
        send_random_set(CAPACITY + 4, VALUES_WIDE);
    endtask

    task automatic test_backpressure();
        // receiver holds off m_ready, so the next sets wait on s_ready until the results drain
        hold_asked++;
        send_random_set(6, VALUES_WIDE);
        send_random_set(3, VALUES_EXTREME);
        send_random_set(9, VALUES_CLUSTERED);
        // sender waits for every result before going on
        wait_results_drained();
        send_random_set(4, VALUES_WIDE);
    endtask

    task automatic test_random_sets();
        int         pick;
        int         size;
        value_mix_t mix;
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        while (requests_sent < ITEMS_TARGET) begin
            if (sets_closed > 30) begin
                tx_quiet = 1'b0;
                rx_quiet = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 80)      size = $urandom_range(1, 12);
            else if (pick < 92) size = $urandom_range(13, 40);
            else if (pick < 97) size = $urandom_range(60, CAPACITY);
            else                size = $urandom_range(CAPACITY + 1, CAPACITY + 6);
            pick = $urandom_range(0, 99);
            if (pick < 60)      mix = VALUES_WIDE;
            else if (pick < 85) mix = VALUES_CLUSTERED;
            else                mix = VALUES_EXTREME;
            send_random_set(size, mix);
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // result checker and receiver stalls
    always @(posedge aclk) begin
        sorted_entry_t due;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (pending_sorted.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing expected", m_sorted_value));
            end else begin
                due = pending_sorted.pop_front();
                if (m_sorted_value !== due.value)
                    report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                              m_sorted_value, due.value));
                if (m_last_out !== due.last)
                    report_mismatch($sformatf("last_out %b, expected %b",
                                              m_last_out, due.last));
                if (m_overflowed !== due.ovf)
                    report_mismatch($sformatf("overflowed %b, expected %b",
                                              m_overflowed, due.ovf));
            end
        end
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left   <= RX_HOLD_CYCLES;
            m_ready     <= 1'b0;
        end else begin
            m_ready <= rx_quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request or result moved for %0d cycles", quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_single_item_sets();
        test_small_sets();
        test_full_capacity();
        test_overflow();
        test_backpressure();
        test_random_sets();
        wait_results_drained();
        repeat (40) @(posedge aclk);
        $display("sent %0d requests in %0d sets, %0d of them over capacity",
                 requests_sent, sets_closed, overflow_sets);
        $display("checked %0d sorted results, %0d mismatches", results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/qse_pkg.sv
hw/rtl/qse_ram.sv
hw/rtl/qse_cmp.sv
hw/rtl/quicksort_engine_unit.sv
tb/sv/tb_quicksort_engine_unit.sv
